@@ hw/rtl/ovlp_pkg.sv @@
package ovlp_pkg;

    localparam int ScoreW  = 16;
    localparam int LenW    = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 64;

    localparam logic [ScoreW-1:0] ScoreMin = 16'h8000;

    localparam logic [CfgIdxW-1:0] CfgRowA = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgRowC = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgRowG = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgRowT = 3'd3;

    localparam logic ModeQuery = 1'b0;
    localparam logic ModeDb    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic append;
        logic col_start;
        logic issue;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic query_empty;
        logic issue_final;
        logic last;
        logic out_free;
    } t_ctrl_sts;

endpackage

@@ hw/rtl/ovlp_ctrl.sv @@
module ovlp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_mode,
    input  logic                  i_last,
    input  ovlp_pkg::t_ctrl_sts   i_sts,
    output logic                  o_in_ready,
    output ovlp_pkg::t_ctrl_cmd   o_cmd
);

    ovlp_pkg::t_state r_state;
    ovlp_pkg::t_state n_state;
    logic             w_accept;

    assign w_accept = i_in_valid && (r_state == ovlp_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ovlp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ovlp_pkg::S_IDLE: begin
                if (w_accept && (i_mode == ovlp_pkg::ModeDb)) begin
                    if (!i_sts.query_empty) begin
                        n_state = ovlp_pkg::S_SCAN;
                    end else if (i_last) begin
                        n_state = ovlp_pkg::S_FINISH;
                    end
                end
            end
            ovlp_pkg::S_SCAN: begin
                if (i_sts.issue_final) begin
                    n_state = ovlp_pkg::S_DRAIN;
                end
            end
            ovlp_pkg::S_DRAIN: begin
                n_state = i_sts.last ? ovlp_pkg::S_FINISH : ovlp_pkg::S_IDLE;
            end
            ovlp_pkg::S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = ovlp_pkg::S_IDLE;
                end
            end
            default: n_state = ovlp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ovlp_pkg::S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.append    = w_accept && (i_mode == ovlp_pkg::ModeQuery);
                o_cmd.col_start = w_accept && (i_mode == ovlp_pkg::ModeDb);
            end
            ovlp_pkg::S_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            ovlp_pkg::S_DRAIN: begin
            end
            ovlp_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hw/rtl/ovlp_dp.sv @@
module ovlp_dp #(
    parameter int QUERY_MAX   = 256,
    parameter int LENGTH_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ovlp_pkg::t_ctrl_cmd                   i_cmd,
    output ovlp_pkg::t_ctrl_sts                   o_sts,
    input  logic [1:0]                            i_symbol,
    input  logic                                  i_last,
    input  logic                                  i_cfg_valid,
    input  logic [ovlp_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [ovlp_pkg::CfgW-1:0]             i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ovlp_pkg::ScoreW-1:0]    o_best_score,
    output logic [ovlp_pkg::LenW-1:0]             o_overlap_length,
    output logic                                  o_match_case
);

    localparam int AW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
    localparam int QW = $clog2(QUERY_MAX + 1);
    localparam logic [31:0] LenCap = (LENGTH_BITS >= 16) ? 32'h0000_FFFF :
                                     32'((64'd1 << LENGTH_BITS) - 64'd1);
    localparam int SW = ovlp_pkg::ScoreW;
    localparam int LW = ovlp_pkg::LenW;

    function automatic logic [LW-1:0] sat_len(input logic [31:0] n);
        logic [LW-1:0] res;
        res = (n > LenCap) ? LenCap[LW-1:0] : n[LW-1:0];
        return res;
    endfunction

    logic [3:0][ovlp_pkg::CfgW-1:0] r_mat;

    logic [1:0]     mem_q [QUERY_MAX];
    logic [SW-1:0]  mem_d [QUERY_MAX];

    logic [QW-1:0]  r_qc;
    logic [LW-1:0]  r_colcnt;
    logic [SW-1:0]  r_rt_best;
    logic [LW-1:0]  r_rt_len;
    logic [1:0]     r_db;
    logic           r_last;
    logic [AW-1:0]  r_raddr;
    logic           r_stg_valid;
    logic           r_stg_final;
    logic [AW-1:0]  r_stg_row;
    logic [1:0]     r_rd_q;
    logic [SW-1:0]  r_rd_d;
    logic [SW-1:0]  r_carry;
    logic [SW-1:0]  r_best;
    logic [LW-1:0]  r_best_len;
    logic           r_out_valid;
    logic [SW-1:0]  r_out_score;
    logic [LW-1:0]  r_out_len;
    logic           r_out_case;

    logic [ovlp_pkg::CfgW-1:0] w_row;
    logic [SW-1:0]             w_m;
    logic [SW-1:0]             w_new;
    logic [QW-1:0]             w_qc_m1;
    logic                      w_room;
    logic                      w_out_free;
    logic                      w_wr_en;
    logic [AW-1:0]             w_wr_addr;
    logic [SW-1:0]             w_wr_data;

    assign w_row      = r_mat[r_db];
    assign w_m        = w_row[{r_rd_q, 4'b0000} +: SW];
    assign w_new      = r_carry + w_m;
    assign w_qc_m1    = r_qc - QW'(1);
    assign w_room     = r_qc < QW'(QUERY_MAX);
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_sts.query_empty = (r_qc == '0);
    assign o_sts.issue_final = (QW'(r_raddr) == w_qc_m1);
    assign o_sts.last        = r_last;
    assign o_sts.out_free    = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ovlp_pkg::CfgRowA: r_mat[0] <= i_cfg_data;
                ovlp_pkg::CfgRowC: r_mat[1] <= i_cfg_data;
                ovlp_pkg::CfgRowG: r_mat[2] <= i_cfg_data;
                ovlp_pkg::CfgRowT: r_mat[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_wr_en   = r_stg_valid || (i_cmd.append && w_room);
    assign w_wr_addr = r_stg_valid ? r_stg_row : r_qc[AW-1:0];
    assign w_wr_data = r_stg_valid ? w_new : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && w_room) begin
            mem_q[r_qc[AW-1:0]] <= i_symbol;
        end
        if (i_cmd.issue) begin
            r_rd_q <= mem_q[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_d[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_d <= mem_d[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qc        <= '0;
            r_colcnt    <= '0;
            r_rt_best   <= ovlp_pkg::ScoreMin;
            r_rt_len    <= '0;
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_stg_valid <= i_cmd.issue;
            if (i_cmd.append && w_room) begin
                r_qc <= r_qc + QW'(1);
            end
            if (i_cmd.col_start && (r_colcnt != '1)) begin
                r_colcnt <= r_colcnt + LW'(1);
            end
            if (r_stg_valid && r_stg_final &&
                ($signed(w_new) >= $signed(r_rt_best))) begin
                r_rt_best <= w_new;
                r_rt_len  <= sat_len(32'(r_colcnt));
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_qc        <= '0;
                r_colcnt    <= '0;
                r_rt_best   <= ovlp_pkg::ScoreMin;
                r_rt_len    <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.col_start) begin
            r_db       <= i_symbol;
            r_last     <= i_last;
            r_raddr    <= '0;
            r_carry    <= '0;
            r_best     <= ovlp_pkg::ScoreMin;
            r_best_len <= '0;
        end
        if (i_cmd.issue) begin
            r_raddr     <= r_raddr + AW'(1);
            r_stg_row   <= r_raddr;
            r_stg_final <= o_sts.issue_final;
        end
        if (r_stg_valid) begin
            r_carry <= r_rd_d;
            if ($signed(w_new) >= $signed(r_best)) begin
                r_best     <= w_new;
                r_best_len <= sat_len(32'(r_stg_row) + 32'd1);
            end
        end
        if (i_cmd.finish) begin
            if (r_qc == '0) begin
                r_out_score <= '0;
                r_out_len   <= '0;
                r_out_case  <= 1'b0;
            end else if ($signed(r_rt_best) >= $signed(r_best)) begin
                r_out_score <= r_rt_best;
                r_out_len   <= r_rt_len;
                r_out_case  <= 1'b1;
            end else begin
                r_out_score <= r_best;
                r_out_len   <= r_best_len;
                r_out_case  <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_best_score     = $signed(r_out_score);
    assign o_overlap_length = r_out_len;
    assign o_match_case     = r_out_case;

endmodule

@@ hw/rtl/overlap_mismatch_scorer.sv @@
// Ungapped prefix-suffix overlap scorer for 2-bit nucleotide codes.
// The input channel carries one item per handshake: mode 0 appends a query
// symbol, mode 1 runs one database symbol against every stored query row.
// A database item with last set closes the job and produces one result item
// with the best score, the overlap length and the overlap case.
// The configuration channel writes the four 64-bit score rows; it is always
// ready and must only be used while the block is idle.
// A query item leaves the block idle. A database item runs a scan over the
// stored query rows, in which the diagonal score memory is read and
// rewritten one row per cycle, then a drain step; with no query rows both
// are skipped. No new item is taken until the block is idle again. A last
// item then passes a finish state, which waits for the output register.
// The result sits in an output register; while the receiver stalls the block
// keeps taking items, and only a following result waits for that register.
// Reset clears the score rows, the query and column counters and the
// run-through best; the query and score memories need no clearing.
module overlap_mismatch_scorer #(
    parameter int QUERY_MAX   = 256,
    parameter int LENGTH_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_mode,
    input  logic [1:0]                            i_symbol,
    input  logic                                  i_last,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ovlp_pkg::ScoreW-1:0]    o_best_score,
    output logic [ovlp_pkg::LenW-1:0]             o_overlap_length,
    output logic                                  o_match_case,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ovlp_pkg::CfgIdxW-1:0]          i_cfg_index,
    input  logic [ovlp_pkg::CfgW-1:0]             i_cfg_data
);

    ovlp_pkg::t_ctrl_cmd w_cmd;
    ovlp_pkg::t_ctrl_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ovlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_last     (i_last),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    ovlp_dp #(
        .QUERY_MAX   (QUERY_MAX),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_symbol         (i_symbol),
        .i_last           (i_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_score     (o_best_score),
        .o_overlap_length (o_overlap_length),
        .o_match_case     (o_match_case)
    );

endmodule

@@ tb/tb_overlap_mismatch_scorer.sv @@
`timescale 1ns / 100ps

module tb_overlap_mismatch_scorer;

    localparam int ScoreW        = ovlp_pkg::ScoreW;
    localparam int LenW          = ovlp_pkg::LenW;
    localparam int CfgIdxW       = ovlp_pkg::CfgIdxW;
    localparam int CfgW          = ovlp_pkg::CfgW;
    localparam int QueryMax      = 256;
    localparam int LengthBits    = 16;
    localparam int LenCap        = (LengthBits >= 16) ? 65535 : (1 << LengthBits) - 1;
    localparam int PhaseItems    = 400;
    localparam int HoldCycles    = 3000;
    localparam int WatchdogLimit = 20000;
    localparam int SettleCycles  = QueryMax + 8;

    localparam logic [1:0] SymA = 2'd0;
    localparam logic [1:0] SymC = 2'd1;
    localparam logic [1:0] SymG = 2'd2;
    localparam logic [1:0] SymT = 2'd3;

    typedef struct packed {
        logic signed [ScoreW-1:0] score;
        logic [LenW-1:0]          length;
        logic                     mcase;
    } t_overlap;

    typedef struct {
        bit                 is_cfg;
        logic               mode;
        logic [1:0]         sym;
        logic               last;
        logic [CfgIdxW-1:0] idx;
        logic [CfgW-1:0]    data;
        bit                 typed;
        t_overlap           want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_mode = 1'b0;
    logic [1:0] i_symbol = 2'd0;
    logic i_last = 1'b0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = '0;
    logic [CfgW-1:0] i_cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    logic signed [ScoreW-1:0] o_best_score;
    logic [LenW-1:0] o_overlap_length;
    logic o_match_case;
    logic o_cfg_ready;

    logic [1:0]               query_sym [QueryMax];
    logic signed [ScoreW-1:0] diag_score [QueryMax];
    logic [CfgW-1:0]          score_row [4];
    int                       query_len;
    int                       col_count;
    logic signed [ScoreW-1:0] run_best;
    int                       run_len;

    t_overlap  pending_overlaps [$];
    t_stim_row stim_tab [$];
    int        mismatch_count = 0;
    int        item_count = 0;
    int        quiet_cycles = 0;
    int        idle_pct = 0;
    int        stall_pct = 0;
    bit        pressure_go = 1'b0;
    logic      hold_off = 1'b0;

    overlap_mismatch_scorer #(
        .QUERY_MAX  (QueryMax),
        .LENGTH_BITS(LengthBits)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_symbol        (i_symbol),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_best_score    (o_best_score),
        .o_overlap_length(o_overlap_length),
        .o_match_case    (o_match_case),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int cap_len(input int n);
        return (n > LenCap) ? LenCap : n;
    endfunction

    function automatic void clear_job();
        for (int r = 0; r < QueryMax; r++) begin
            diag_score[r] = '0;
        end
        query_len = 0;
        col_count = 0;
        run_best  = ovlp_pkg::ScoreMin;
        run_len   = 0;
    endfunction

    function automatic bit predict_overlap(input logic mode, input logic [1:0] sym,
                                           input logic last, output t_overlap res);
        logic signed [ScoreW-1:0] prev;
        logic signed [ScoreW-1:0] pick;
        res = '0;
        if (mode == ovlp_pkg::ModeQuery) begin
            if (query_len < QueryMax) begin
                query_sym[query_len]  = sym;
                diag_score[query_len] = '0;
                query_len++;
            end
            return 1'b0;
        end
        for (int r = query_len - 1; r >= 0; r--) begin
            prev = (r == 0) ? '0 : diag_score[r-1];
            diag_score[r] = prev + score_row[sym][16*query_sym[r] +: 16];
        end
        if (col_count < 65535) begin
            col_count++;
        end
        if (query_len > 0) begin
            if (diag_score[query_len-1] >= run_best) begin
                run_best = diag_score[query_len-1];
                run_len  = cap_len(col_count);
            end
        end
        if (!last) begin
            return 1'b0;
        end
        if (query_len > 0) begin
            pick = diag_score[0];
            for (int r = 0; r < query_len; r++) begin
                if (diag_score[r] >= pick) begin
                    pick       = diag_score[r];
                    res.length = LenW'(cap_len(r + 1));
                end
            end
            res.score = pick;
            if (run_best >= pick) begin
                res.score  = run_best;
                res.length = LenW'(run_len);
                res.mcase  = 1'b1;
            end
        end
        clear_job();
        return 1'b1;
    endfunction

    function automatic logic [ScoreW-1:0] pick_score();
        int k;
        logic signed [ScoreW-1:0] v;
        k = $urandom_range(99);
        if (k < 50) begin
            v = ScoreW'($urandom_range(6));
            v = v - 16'sd3;
        end else if (k < 75) begin
            case ($urandom_range(3))
                0: v = 16'sh7FFF;
                1: v = ovlp_pkg::ScoreMin;
                2: v = '0;
                default: v = '1;
            endcase
        end else begin
            v = ScoreW'($urandom);
        end
        return v;
    endfunction

    function automatic logic [CfgW-1:0] random_row();
        logic [CfgW-1:0] v;
        for (int q = 0; q < 4; q++) begin
            v[16*q +: 16] = pick_score();
        end
        return v;
    endfunction

    function automatic void tab_item(input logic mode, input logic [1:0] sym, input logic last);
        t_stim_row row;
        row = '{default: 0};
        row.mode = mode;
        row.sym  = sym;
        row.last = last;
        stim_tab.push_back(row);
    endfunction

    function automatic void tab_typed(input logic mode, input logic [1:0] sym, input logic last,
                                      input int score, input int length, input logic mcase);
        t_stim_row row;
        row = '{default: 0};
        row.mode        = mode;
        row.sym         = sym;
        row.last        = last;
        row.typed       = 1'b1;
        row.want.score  = ScoreW'(score);
        row.want.length = LenW'(length);
        row.want.mcase  = mcase;
        stim_tab.push_back(row);
    endfunction

    function automatic void tab_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        t_stim_row row;
        row = '{default: 0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        stim_tab.push_back(row);
    endfunction

    task automatic send_item(input logic mode, input logic [1:0] sym, input logic last,
                             input bit typed, input t_overlap typed_res);
        t_overlap res;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_symbol   <= sym;
        i_last     <= last;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        if (predict_overlap(mode, sym, last, res)) begin
            pending_overlaps.push_back(typed ? typed_res : res);
        end
        item_count++;
    endtask

    task automatic write_row(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_overlaps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        score_row[idx[1:0]] = data;
    endtask

    task automatic run_job();
        int nq;
        int ncol;
        int k;
        k = $urandom_range(99);
        if (k < 6) begin
            nq = 0;
        end else if (k < 9) begin
            nq = $urandom_range(QueryMax + 40, QueryMax - 10);
        end else begin
            nq = $urandom_range(12, 1);
        end
        ncol = (nq > 12) ? $urandom_range(4, 1) : $urandom_range(16, 1);
        for (int q = 0; q < nq; q++) begin
            send_item(ovlp_pkg::ModeQuery, 2'($urandom_range(3)), $urandom_range(4) == 0,
                      1'b0, '0);
        end
        for (int c = 0; c < ncol; c++) begin
            if ($urandom_range(99) < 8) begin
                send_item(ovlp_pkg::ModeQuery, 2'($urandom_range(3)), 1'($urandom_range(1)),
                          1'b0, '0);
            end
            send_item(ovlp_pkg::ModeDb, 2'($urandom_range(3)),
                      (c == ncol - 1) && ($urandom_range(99) >= 5), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input bit pressure);
        int target;
        idle_pct   = idle;
        stall_pct  <= stall;
        write_row(ovlp_pkg::CfgRowA, random_row());
        write_row(ovlp_pkg::CfgRowC, random_row());
        write_row(ovlp_pkg::CfgRowG, random_row());
        write_row(ovlp_pkg::CfgRowT, random_row());
        if (pressure) begin
            pressure_go = 1'b1;
        end
        target = item_count + PhaseItems;
        while (item_count < target) begin
            run_job();
        end
    endtask

    initial begin : receiver_hold
        wait (pressure_go);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HoldCycles) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin : result_check
        t_overlap want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_overlaps.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result: score %0d length %0d case %0d",
                             o_best_score, o_overlap_length, o_match_case);
                end
                mismatch_count++;
            end else begin
                want = pending_overlaps.pop_front();
                if (o_best_score !== want.score || o_overlap_length !== want.length ||
                    o_match_case !== want.mcase) begin
                    if (mismatch_count < 10) begin
                        $display({"mismatch: expected score %0d length %0d case %0d, ",
                                  "got %0d %0d %0d"},
                                 want.score, want.length, want.mcase,
                                 o_best_score, o_overlap_length, o_match_case);
                    end
                    mismatch_count++;
                end
            end
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("overlap_mismatch_scorer verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_stim_row row;
        clear_job();
        for (int k = 0; k < 4; k++) begin
            score_row[k] = '0;
        end

        // Empty query, ignored last on a query item, then a one-row job with a zero matrix.
        tab_typed(ovlp_pkg::ModeDb, SymT, 1'b1, 0, 0, 1'b0);
        tab_item(ovlp_pkg::ModeQuery, SymA, 1'b1);
        tab_typed(ovlp_pkg::ModeDb, SymG, 1'b1, 0, 1, 1'b1);
        tab_cfg(ovlp_pkg::CfgRowA, {4{16'h7FFF}});
        tab_cfg(ovlp_pkg::CfgRowC, {4{16'h8000}});
        tab_cfg(ovlp_pkg::CfgRowG, 64'h0001_FFFF_0002_0003);
        tab_cfg(ovlp_pkg::CfgRowT, {4{16'hFFFF}});
        // Wrapping sums, and a query row that joins after database columns.
        tab_item(ovlp_pkg::ModeQuery, SymA, 1'b0);
        tab_item(ovlp_pkg::ModeQuery, SymC, 1'b0);
        tab_item(ovlp_pkg::ModeQuery, SymG, 1'b0);
        tab_item(ovlp_pkg::ModeQuery, SymT, 1'b0);
        tab_item(ovlp_pkg::ModeDb, SymA, 1'b0);
        tab_item(ovlp_pkg::ModeDb, SymA, 1'b0);
        tab_item(ovlp_pkg::ModeDb, SymC, 1'b0);
        tab_item(ovlp_pkg::ModeQuery, SymG, 1'b0);
        tab_item(ovlp_pkg::ModeDb, SymT, 1'b0);
        tab_item(ovlp_pkg::ModeDb, SymG, 1'b1);
        tab_item(ovlp_pkg::ModeQuery, SymT, 1'b0);
        tab_typed(ovlp_pkg::ModeDb, SymC, 1'b1, -32768, 1, 1'b1);
        tab_item(ovlp_pkg::ModeQuery, SymA, 1'b0);
        tab_typed(ovlp_pkg::ModeDb, SymA, 1'b1, 32767, 1, 1'b1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_tab[k]) begin
            row = stim_tab[k];
            if (row.is_cfg) begin
                write_row(row.idx, row.data);
            end else begin
                send_item(row.mode, row.sym, row.last, row.typed, row.want);
            end
        end

        run_phase(0, 0, 1'b1);
        run_phase(46, 0, 1'b0);
        run_phase(0, 46, 1'b0);
        run_phase(35, 35, 1'b0);

        i_in_valid <= 1'b0;
        while (pending_overlaps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("overlap_mismatch_scorer verification clean");
        end else begin
            $display("overlap_mismatch_scorer verification failed");
        end
        $finish;
    end

endmodule
